>>> hw/rtl/ilir_pkg.sv
package ilir_pkg;

  localparam int OP_W     = 4;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int IN_W     = OP_W + POS_W + VAL_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT     = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
  localparam logic [OP_W-1:0] OP_READ_FWD   = 4'd6;
  localparam logic [OP_W-1:0] OP_READ_REV   = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_INSERT,
    CC_REMOVE,
    CC_ROT_DOWN,
    CC_ROT_UP
  } cell_cmd_t;

endpackage

>>> hw/rtl/indexed_list_insert_remove.sv
// Bounded ordered list of up to DEPTH signed 32-bit entries held in a row of cells, one entry
// per cell, front at cell 0. Every push, insert, pop and remove shifts the cells from its
// position to the end of the row by one place, a clear only zeroes the count, and each such
// command returns a single result transaction, so the block takes one such command per cycle
// while the result side keeps up. A read forward or reverse returns one result per stored
// entry (one result for an empty list), one per cycle while the result side keeps up, by
// rotating the row through cell 0 or the tail cell, and the next command is taken after the
// last result of the run is registered. The output register decouples the two sides, so a new
// command is taken while an earlier result is being handed over.
module indexed_list_insert_remove #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // op [3:0], position [8:4], value [40:9], zero fill above.
  input  logic [ilir_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status [1:0], element [33:2], length above it, zero fill above.
  output logic [((ilir_pkg::STATUS_W + ilir_pkg::VAL_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
               m_tdata,
  output logic m_tlast
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W;
  localparam int OW   = ilir_pkg::STATUS_W + ilir_pkg::VAL_W + CW;
  localparam int OTW  = ((OW + 7) / 8) * 8;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                         state;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [CW-1:0]                rem;
  logic                         rd_rev;

  logic [ilir_pkg::OP_W-1:0]    in_op;
  logic [ilir_pkg::POS_W-1:0]   in_pos;
  logic [ilir_pkg::VAL_W-1:0]   in_value;

  logic                         out_free;
  logic                         fire;
  logic                         read_step;
  logic                         go_read;
  logic                         full;
  logic                         empty;
  logic [CMPW-1:0]              pos_x;
  logic [CMPW-1:0]              cnt_x;
  logic [IW-1:0]                tail_idx;

  logic [ilir_pkg::STATUS_W-1:0] st;
  ilir_pkg::cell_cmd_t           cmd;
  logic [IW-1:0]                 cpos;
  logic [ilir_pkg::VAL_W-1:0]    new_value;
  logic [ilir_pkg::VAL_W-1:0]    cell_q [DEPTH];

  logic [ilir_pkg::STATUS_W-1:0] m_status;
  logic signed [ilir_pkg::VAL_W-1:0] m_element;
  logic [CW-1:0]                 m_length;

  assign in_op    = s_tdata[3:0];
  assign in_pos   = s_tdata[8:4];
  assign in_value = s_tdata[40:9];

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign fire      = s_tvalid && s_tready;
  assign read_step = (state == S_READ) && out_free;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pos_x    = CMPW'(in_pos);
  assign cnt_x    = CMPW'(count);
  assign tail_idx = IW'(count - 1'b1);

  always_comb begin
    st         = ilir_pkg::ST_OK;
    cmd        = ilir_pkg::CC_HOLD;
    cpos       = '0;
    new_value  = in_value;
    count_next = count;
    go_read    = 1'b0;
    if (fire) begin
      case (in_op)
        ilir_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            st = ilir_pkg::ST_FULL;
          end else begin
            cmd        = ilir_pkg::CC_INSERT;
            count_next = count + 1'b1;
          end
        end
        ilir_pkg::OP_PUSH_BACK: begin
          if (full) begin
            st = ilir_pkg::ST_FULL;
          end else begin
            cmd        = ilir_pkg::CC_INSERT;
            cpos       = IW'(count);
            count_next = count + 1'b1;
          end
        end
        ilir_pkg::OP_INSERT: begin
          if (pos_x > cnt_x) begin
            st = ilir_pkg::ST_RANGE;
          end else if (full) begin
            st = ilir_pkg::ST_FULL;
          end else begin
            cmd        = ilir_pkg::CC_INSERT;
            cpos       = IW'(in_pos);
            count_next = count + 1'b1;
          end
        end
        ilir_pkg::OP_POP_FRONT: begin
          if (empty) begin
            st = ilir_pkg::ST_EMPTY;
          end else begin
            cmd        = ilir_pkg::CC_REMOVE;
            count_next = count - 1'b1;
          end
        end
        ilir_pkg::OP_POP_BACK: begin
          if (empty) begin
            st = ilir_pkg::ST_EMPTY;
          end else begin
            cmd        = ilir_pkg::CC_REMOVE;
            cpos       = tail_idx;
            count_next = count - 1'b1;
          end
        end
        ilir_pkg::OP_REMOVE: begin
          if (empty && (in_pos == '0)) begin
            st = ilir_pkg::ST_EMPTY;
          end else if (pos_x >= cnt_x) begin
            st = ilir_pkg::ST_RANGE;
          end else begin
            cmd        = ilir_pkg::CC_REMOVE;
            cpos       = IW'(in_pos);
            count_next = count - 1'b1;
          end
        end
        ilir_pkg::OP_READ_FWD, ilir_pkg::OP_READ_REV: begin
          go_read = !empty;
        end
        ilir_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
          st = ilir_pkg::ST_RANGE;
        end
      endcase
    end else if (read_step) begin
      if (rd_rev) begin
        cmd       = ilir_pkg::CC_ROT_UP;
        cpos      = '0;
        new_value = cell_q[tail_idx];
      end else begin
        cmd       = ilir_pkg::CC_ROT_DOWN;
        cpos      = tail_idx;
        new_value = cell_q[0];
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ilir_pkg::VAL_W-1:0] left_in;
    logic [ilir_pkg::VAL_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_q[i+1];
    end
    ilir_cell #(
      .DEPTH(DEPTH),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .cmd(cmd),
      .pos(cpos),
      .new_value(new_value),
      .left(left_in),
      .right(right_in),
      .q(cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rem      <= '0;
      rd_rev   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        m_tvalid <= !go_read;
        if (go_read) begin
          state  <= S_READ;
          rem    <= count;
          rd_rev <= (in_op == ilir_pkg::OP_READ_REV);
        end
      end else if (read_step) begin
        m_tvalid <= 1'b1;
        rem      <= rem - 1'b1;
        if (rem == CW'(1)) begin
          state <= S_IDLE;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_status  <= st;
      m_element <= '0;
      m_length  <= count_next;
      m_tlast   <= 1'b1;
    end else if (read_step) begin
      m_status  <= ilir_pkg::ST_OK;
      m_element <= rd_rev ? cell_q[tail_idx] : cell_q[0];
      m_length  <= count;
      m_tlast   <= (rem == CW'(1));
    end
  end

  assign m_tdata = OTW'({m_length, m_element, m_status});

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("List count exceeds the storage depth.");

  a_read_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ((rem != '0) && (rem <= count)))
    else $error("Read run has no entries left to return.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> (m_tvalid || (state == S_READ)))
    else $error("Accepted transaction produced neither a result nor a read run.");

  a_count_steady_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(count))
    else $error("List count changed during a read run.");

endmodule

>>> hw/rtl/ilir_cell.sv
module ilir_cell #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  ilir_pkg::cell_cmd_t              cmd,
  input  logic [$clog2(DEPTH)-1:0]         pos,
  input  logic [ilir_pkg::VAL_W-1:0]       new_value,
  input  logic [ilir_pkg::VAL_W-1:0]       left,
  input  logic [ilir_pkg::VAL_W-1:0]       right,
  output logic [ilir_pkg::VAL_W-1:0]       q
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

  logic [ilir_pkg::VAL_W-1:0] q_next;
  logic                       at_pos;
  logic                       above_pos;

  assign at_pos    = (MY_INDEX == pos);
  assign above_pos = (MY_INDEX > pos);

  always_comb begin
    q_next = q;
    case (cmd)
      ilir_pkg::CC_INSERT: begin
        if (at_pos) begin
          q_next = new_value;
        end else if (above_pos) begin
          q_next = left;
        end
      end
      ilir_pkg::CC_REMOVE: begin
        if (at_pos || above_pos) begin
          q_next = right;
        end
      end
      ilir_pkg::CC_ROT_DOWN: begin
        q_next = at_pos ? new_value : right;
      end
      ilir_pkg::CC_ROT_UP: begin
        q_next = at_pos ? new_value : left;
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
